@@ rtl/core/ellp_pkg.sv @@
// Shared types, constants and saturating helpers for the ellipse evaluator.
// Used by the rotation cell and the top level; no dependencies.
package ellp_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int WORD_BITS_DEF  = 32;
  localparam int CORDIC_STEPS   = 24;

  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

  localparam logic signed [32:0] ATAN_TURNS [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81
  };

  // Configuration register indexes
  localparam logic [2:0] REG_ALPHA_X = 3'd0;
  localparam logic [2:0] REG_ALPHA_Y = 3'd1;
  localparam logic [2:0] REG_BETA_X  = 3'd2;
  localparam logic [2:0] REG_BETA_Y  = 3'd3;
  localparam logic [2:0] REG_GAMMA_X = 3'd4;
  localparam logic [2:0] REG_GAMMA_Y = 3'd5;

  typedef struct packed {
    logic               vld;
    logic [1:0]         quad;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cordic_t;

  // Saturating 64-bit signed add
  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  // Round p / 2^30 to nearest, ties away from zero
  function automatic logic signed [34:0] rnd30(input logic signed [63:0] p);
    logic [63:0] m;
    logic [33:0] q;
    m = p[63] ? 64'(-p) : 64'(p);
    q = 34'((m + 64'd536870912) >> 30);
    return p[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

@@ rtl/core/ellp_cordic_cell.sv @@
// One rotation step of the sine/cosine chain: a registered micro-rotation.
// Depends on ellp_pkg for the transaction type and arctangent table.
module ellp_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  ellp_pkg::cordic_t din,
  output ellp_pkg::cordic_t dout
);

  logic               vld_r;
  logic [1:0]         quad_r;
  logic signed [33:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [32:0] z_r, z_nxt;

  // Rotate toward zero residual angle
  always_comb begin
    if (!din.z[32]) begin
      x_nxt = din.x - (din.y >>> STEP);
      y_nxt = din.y + (din.x >>> STEP);
      z_nxt = din.z - ellp_pkg::ATAN_TURNS[STEP];
    end else begin
      x_nxt = din.x + (din.y >>> STEP);
      y_nxt = din.y - (din.x >>> STEP);
      z_nxt = din.z + ellp_pkg::ATAN_TURNS[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r <= din.quad;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign dout = '{vld: vld_r, quad: quad_r, x: x_r, y: y_r, z: z_r};

endmodule

@@ rtl/core/ellipse_point_derivative_eval.sv @@
// Parametric ellipse evaluator: phase in, point, derivatives and norms out.
// Depends on ellp_pkg and ellp_cordic_cell.
//
// Each input transaction carries a phase (a full turn is 2^ANGLE_BITS counts).
// A row of 24 rotation cells, one per CORDIC step, forms cosine and sine;
// seven arithmetic stages then form v, v', v'', |v|^2 and its derivatives and
// the unit circle residual. The block accepts one transaction per clock while
// in_stall is low; the whole pipe advances together, so a stall on the result
// side holds every stage and is passed straight back as in_stall. Results are
// registered at the output port. Configuration writes are taken at any time
// but must only be made while no transaction is in flight; terms built only
// from the registers settle through their own product and sum registers after
// a write.
module ellipse_point_derivative_eval #(
  parameter int ANGLE_BITS = ellp_pkg::ANGLE_BITS_DEF,
  parameter int WORD_BITS  = ellp_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_phase,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_slope_x,
  output logic signed [31:0] out_slope_y,
  output logic signed [31:0] out_bend_x,
  output logic signed [31:0] out_bend_y,
  output logic [62:0]        out_norm_sq,
  output logic signed [63:0] out_norm_sq_d1,
  output logic signed [63:0] out_norm_sq_d2,
  output logic signed [63:0] out_residual
);

  localparam int NSTEP = ellp_pkg::CORDIC_STEPS;
  localparam logic signed [35:0] W_HI = (36'sd1 <<< (WORD_BITS - 1)) - 36'sd1;
  localparam logic signed [35:0] W_LO = -W_HI - 36'sd1;
  localparam logic signed [63:0] MINUS_ONE_Q32 = -(64'sd1 <<< 32);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

  function automatic logic signed [31:0] satw(input logic signed [35:0] v);
    logic signed [35:0] r;
    if (v > W_HI) r = W_HI;
    else if (v < W_LO) r = W_LO;
    else r = v;
    return r[31:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [31:0] ax_r, ay_r, bx_r, by_r, gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; bx_r <= '0;
      by_r <= '0; gx_r <= '0; gy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ellp_pkg::REG_ALPHA_X: ax_r <= cfg_wdata;
        ellp_pkg::REG_ALPHA_Y: ay_r <= cfg_wdata;
        ellp_pkg::REG_BETA_X:  bx_r <= cfg_wdata;
        ellp_pkg::REG_BETA_Y:  by_r <= cfg_wdata;
        ellp_pkg::REG_GAMMA_X: gx_r <= cfg_wdata;
        ellp_pkg::REG_GAMMA_Y: gy_r <= cfg_wdata;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Register-only terms of the residual, rebuilt every clock
  logic signed [63:0] k_axax_r, k_ayay_r, k_bxbx_r, k_byby_r;
  logic signed [63:0] k_axgx_r, k_aygy_r, k_bxgx_r, k_bygy_r, k_gxgx_r, k_gygy_r;
  logic signed [63:0] k_aa_r, k_bb_r, k_ag2_r, k_bg2_r, k_gg_r;
  logic [63:0]        k_abs_r [4];
  logic               k_neg_r [4];

  always_ff @(posedge clk) begin
    k_axax_r <= ax_r * ax_r;  k_ayay_r <= ay_r * ay_r;
    k_bxbx_r <= bx_r * bx_r;  k_byby_r <= by_r * by_r;
    k_axgx_r <= ax_r * gx_r;  k_aygy_r <= ay_r * gy_r;
    k_bxgx_r <= bx_r * gx_r;  k_bygy_r <= by_r * gy_r;
    k_gxgx_r <= gx_r * gx_r;  k_gygy_r <= gy_r * gy_r;
    k_aa_r  <= ellp_pkg::sadd(k_axax_r, k_ayay_r);
    k_bb_r  <= ellp_pkg::sadd(k_bxbx_r, k_byby_r);
    k_ag2_r <= ellp_pkg::sadd(ellp_pkg::sadd(k_axgx_r, k_aygy_r),
                              ellp_pkg::sadd(k_axgx_r, k_aygy_r));
    k_bg2_r <= ellp_pkg::sadd(ellp_pkg::sadd(k_bxgx_r, k_bygy_r),
                              ellp_pkg::sadd(k_bxgx_r, k_bygy_r));
    k_gg_r  <= ellp_pkg::sadd(k_gxgx_r, k_gygy_r);
    k_abs_r[0] <= k_aa_r;
    k_abs_r[1] <= k_bb_r;
    k_abs_r[2] <= k_ag2_r[63] ? 64'(-k_ag2_r) : 64'(k_ag2_r);
    k_abs_r[3] <= k_bg2_r[63] ? 64'(-k_bg2_r) : 64'(k_bg2_r);
    k_neg_r[0] <= 1'b0;
    k_neg_r[1] <= 1'b0;
    k_neg_r[2] <= k_ag2_r[63];
    k_neg_r[3] <= k_bg2_r[63];
  end

  // ---------------------------------------------------------------- flow
  logic adv;
  logic out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // ---------------------------------------------------------------- CORDIC row
  logic [31:0]       turn, turn_sh;
  ellp_pkg::cordic_t chain [NSTEP + 1];

  // Rotate by an eighth of a turn so the top two bits give the quadrant
  assign turn    = 32'(in_phase) << (32 - ANGLE_BITS);
  assign turn_sh = turn + 32'h2000_0000;
  assign chain[0] = '{vld: in_valid, quad: turn_sh[31:30],
                      x: ellp_pkg::CORDIC_GAIN_Q30, y: 34'sd0,
                      z: $signed({3'b000, turn_sh[29:0]}) - 33'sd536870912};

  for (genvar g = 0; g < NSTEP; g++) begin : g_cell
    ellp_cordic_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (adv),
      .din  (chain[g]),
      .dout (chain[g + 1])
    );
  end

  // ---------------------------------------------------------------- P0: cos/sin
  logic signed [33:0] cx, cy;
  logic signed [31:0] c_nxt, s_nxt, c0_r, s0_r;
  logic               v0_r;

  always_comb begin
    if (chain[NSTEP].x > 34'(ellp_pkg::ONE_Q30)) cx = 34'(ellp_pkg::ONE_Q30);
    else if (chain[NSTEP].x < -34'(ellp_pkg::ONE_Q30)) cx = -34'(ellp_pkg::ONE_Q30);
    else cx = chain[NSTEP].x;
    if (chain[NSTEP].y > 34'(ellp_pkg::ONE_Q30)) cy = 34'(ellp_pkg::ONE_Q30);
    else if (chain[NSTEP].y < -34'(ellp_pkg::ONE_Q30)) cy = -34'(ellp_pkg::ONE_Q30);
    else cy = chain[NSTEP].y;
    unique case (chain[NSTEP].quad)
      2'd0:    begin c_nxt = cx[31:0];     s_nxt = cy[31:0];     end
      2'd1:    begin c_nxt = -cy[31:0];    s_nxt = cx[31:0];     end
      2'd2:    begin c_nxt = -cx[31:0];    s_nxt = -cy[31:0];    end
      default: begin c_nxt = cy[31:0];     s_nxt = -cx[31:0];    end
    endcase
  end

  // ---------------------------------------------------------------- pipe regs
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [31:0] c1_r, s1_r, c2q_r, s2q_r;
  logic signed [63:0] p_axc_r, p_bxs_r, p_ayc_r, p_bys_r;
  logic signed [63:0] p_bxc_r, p_axs_r, p_byc_r, p_ays_r, p_cc_r, p_ss_r;
  logic signed [34:0] rx, ry;
  logic signed [31:0] vx2_r, vy2_r, d1x2_r, d1y2_r, d2x2_r, d2y2_r;
  logic signed [34:0] c2_r, s2_r;
  logic signed [31:0] vx3_r, vy3_r, d1x3_r, d1y3_r, d2x3_r, d2y3_r;
  logic signed [63:0] q_vxvx_r, q_vyvy_r, q_vxd1_r, q_vyd1_r;
  logic signed [63:0] q_d1xx_r, q_d1yy_r, q_vxd2_r, q_vyd2_r;
  logic [62:0]        mq_hi_r [4];
  logic [62:0]        mq_lo_r [4];
  logic               mq_neg_r [4];
  logic signed [31:0] bsel [4];
  logic [30:0]        ub [4];
  logic signed [31:0] vx4_r, vy4_r, d1x4_r, d1y4_r, d2x4_r, d2y4_r;
  logic signed [63:0] nsq4_r, dvd1_r, dd1_r, dvd2_r;
  logic signed [63:0] m_r [4];
  logic signed [63:0] m_nxt [4];
  logic [64:0]        mq_t [4];
  logic signed [31:0] vx5_r, vy5_r, d1x5_r, d1y5_r, d2x5_r, d2y5_r;
  logic signed [63:0] nsq5_r, n1_r, n2_r, ra_r, m4_r;
  logic signed [63:0] res_nxt;
  logic signed [31:0] o_px_r, o_py_r, o_sx_r, o_sy_r, o_bx_r, o_by_r;
  logic signed [63:0] o_nsq_r, o_n1_r, o_n2_r, o_res_r;

  assign rx = ellp_pkg::rnd30(p_axc_r + p_bxs_r);
  assign ry = ellp_pkg::rnd30(p_ayc_r + p_bys_r);

  // Second operand of each residual product and its magnitude
  assign bsel[0] = c2_r[31:0];
  assign bsel[1] = s2_r[31:0];
  assign bsel[2] = c2q_r;
  assign bsel[3] = s2q_r;
  for (genvar k = 0; k < 4; k++) begin : g_ub
    assign ub[k] = bsel[k][31] ? 31'(-bsel[k]) : 31'(bsel[k]);
    // Reassemble |a|*|b| / 2^30 from the two halves of |a|, then saturate
    assign mq_t[k] = {mq_hi_r[k], 2'b00}
                   + 65'((65'(mq_lo_r[k]) + 65'd536870912) >> 30);
    always_comb begin
      if (!mq_neg_r[k]) begin
        m_nxt[k] = (mq_t[k] > 65'(S64_MAX)) ? S64_MAX : $signed(mq_t[k][63:0]);
      end else if (mq_t[k] >= (65'd1 << 63)) begin
        m_nxt[k] = {1'b1, 63'd0};
      end else begin
        m_nxt[k] = -$signed(mq_t[k][63:0]);
      end
    end
  end

  always_comb begin
    res_nxt = ellp_pkg::sadd(ra_r, m4_r);
    res_nxt = ellp_pkg::sadd(res_nxt, k_gg_r);
    res_nxt = ellp_pkg::sadd(res_nxt, MINUS_ONE_Q32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r <= chain[NSTEP].vld;
      v1_r <= v0_r; v2_r <= v1_r; v3_r <= v2_r;
      v4_r <= v3_r; v5_r <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // P0: quadrant folding
      c0_r <= c_nxt;
      s0_r <= s_nxt;
      // P1: axis products
      p_axc_r <= ax_r * c0_r;  p_bxs_r <= bx_r * s0_r;
      p_ayc_r <= ay_r * c0_r;  p_bys_r <= by_r * s0_r;
      p_bxc_r <= bx_r * c0_r;  p_axs_r <= ax_r * s0_r;
      p_byc_r <= by_r * c0_r;  p_ays_r <= ay_r * s0_r;
      p_cc_r  <= c0_r * c0_r;  p_ss_r  <= s0_r * s0_r;
      c1_r <= c0_r;
      s1_r <= s0_r;
      // P2: round, offset and saturate the vectors
      vx2_r  <= satw(36'(rx) + 36'(gx_r));
      vy2_r  <= satw(36'(ry) + 36'(gy_r));
      d1x2_r <= satw(36'(ellp_pkg::rnd30(p_bxc_r - p_axs_r)));
      d1y2_r <= satw(36'(ellp_pkg::rnd30(p_byc_r - p_ays_r)));
      d2x2_r <= satw(-36'(rx));
      d2y2_r <= satw(-36'(ry));
      c2_r   <= ellp_pkg::rnd30(p_cc_r);
      s2_r   <= ellp_pkg::rnd30(p_ss_r);
      c2q_r  <= c1_r;
      s2q_r  <= s1_r;
      // P3: scalar products and split residual products
      q_vxvx_r <= vx2_r * vx2_r;   q_vyvy_r <= vy2_r * vy2_r;
      q_vxd1_r <= vx2_r * d1x2_r;  q_vyd1_r <= vy2_r * d1y2_r;
      q_d1xx_r <= d1x2_r * d1x2_r; q_d1yy_r <= d1y2_r * d1y2_r;
      q_vxd2_r <= vx2_r * d2x2_r;  q_vyd2_r <= vy2_r * d2y2_r;
      for (int k = 0; k < 4; k++) begin
        mq_hi_r[k]  <= 63'(k_abs_r[k][63:32]) * 63'(ub[k]);
        mq_lo_r[k]  <= 63'(k_abs_r[k][31:0]) * 63'(ub[k]);
        mq_neg_r[k] <= k_neg_r[k] ^ bsel[k][31];
      end
      vx3_r <= vx2_r; vy3_r <= vy2_r; d1x3_r <= d1x2_r;
      d1y3_r <= d1y2_r; d2x3_r <= d2x2_r; d2y3_r <= d2y2_r;
      // P4: dot products and residual terms
      nsq4_r <= ellp_pkg::sadd(q_vxvx_r, q_vyvy_r);
      dvd1_r <= ellp_pkg::sadd(q_vxd1_r, q_vyd1_r);
      dd1_r  <= ellp_pkg::sadd(q_d1xx_r, q_d1yy_r);
      dvd2_r <= ellp_pkg::sadd(q_vxd2_r, q_vyd2_r);
      for (int k = 0; k < 4; k++) begin
        m_r[k] <= m_nxt[k];
      end
      vx4_r <= vx3_r; vy4_r <= vy3_r; d1x4_r <= d1x3_r;
      d1y4_r <= d1y3_r; d2x4_r <= d2x3_r; d2y4_r <= d2y3_r;
      // P5: doublings and the first half of the residual sum
      nsq5_r <= nsq4_r;
      n1_r   <= ellp_pkg::sadd(dvd1_r, dvd1_r);
      n2_r   <= ellp_pkg::sadd(ellp_pkg::sadd(dd1_r, dd1_r),
                               ellp_pkg::sadd(dvd2_r, dvd2_r));
      ra_r   <= ellp_pkg::sadd(ellp_pkg::sadd(m_r[0], m_r[1]), m_r[2]);
      m4_r   <= m_r[3];
      vx5_r <= vx4_r; vy5_r <= vy4_r; d1x5_r <= d1x4_r;
      d1y5_r <= d1y4_r; d2x5_r <= d2x4_r; d2y5_r <= d2y4_r;
      // Output register
      o_px_r <= vx5_r;  o_py_r <= vy5_r;
      o_sx_r <= d1x5_r; o_sy_r <= d1y5_r;
      o_bx_r <= d2x5_r; o_by_r <= d2y5_r;
      o_nsq_r <= nsq5_r;
      o_n1_r  <= n1_r;
      o_n2_r  <= n2_r;
      o_res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = o_px_r;
  assign out_point_y    = o_py_r;
  assign out_slope_x    = o_sx_r;
  assign out_slope_y    = o_sy_r;
  assign out_bend_x     = o_bx_r;
  assign out_bend_y     = o_by_r;
  assign out_norm_sq    = o_nsq_r[62:0];
  assign out_norm_sq_d1 = o_n1_r;
  assign out_norm_sq_d2 = o_n2_r;
  assign out_residual   = o_res_r;

  // ---------------------------------------------------------------- checks
  a_cos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> (c0_r <= ellp_pkg::ONE_Q30) && (c0_r >= -ellp_pkg::ONE_Q30))
    else $error("cosine outside unit range");

  a_norm_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> !nsq4_r[63])
    else $error("squared length negative");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v3_r) && $stable(o_res_r))
    else $error("pipeline moved while held");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !v5_r) |=> !out_valid_r)
    else $error("result repeated after delivery");

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the parametric ellipse evaluator: directed and random phases.
// Depends on ellp_pkg and ellipse_point_derivative_eval; expected values not typed in
// come from a bit-accurate CORDIC and saturating fixed-point predictor kept here.
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DRAIN  = 40;   // allow slack for results still in the pipe
  localparam int CFG_SETTLE  = 5;    // wait for the register-only terms to settle after a write

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic signed [31:0] bend_x;
    logic signed [31:0] bend_y;
    logic [62:0]        norm_sq;
    logic signed [63:0] norm_sq_d1;
    logic signed [63:0] norm_sq_d2;
    logic signed [63:0] residual;
  } ellipse_result_t;

  // One phase to send; typed_in marks a row whose expectation is written out by hand
  typedef struct packed {
    logic            typed_in;
    logic [15:0]     phase;
    ellipse_result_t want;
  } phase_job_t;

  typedef struct {
    int              cfg_set;
    phase_job_t      job;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [15:0] in_phase;
  logic out_valid;
  logic out_stall;
  ellipse_result_t got;

  // Local copy of the six axis/centre registers, sign extended
  logic signed [63:0] ax, ay, bx, by, gx, gy;

  phase_job_t      job_q[$];
  ellipse_result_t pending_q[$];
  phase_job_t      cur_job;
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycles;

  ellipse_point_derivative_eval DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_phase(in_phase),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(got.point_x), .out_point_y(got.point_y),
    .out_slope_x(got.slope_x), .out_slope_y(got.slope_y),
    .out_bend_x(got.bend_x), .out_bend_y(got.bend_y),
    .out_norm_sq(got.norm_sq), .out_norm_sq_d1(got.norm_sq_d1),
    .out_norm_sq_d2(got.norm_sq_d2), .out_residual(got.residual)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the evaluator
  // ---------------------------------------------------------------------------

  // Add with clamping to the signed 64-bit range
  function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Divide by 2^30, rounding to nearest with ties away from zero
  function automatic logic signed [63:0] round_q30(input logic signed [63:0] p);
    logic [63:0] m;
    m = p[63] ? -p : p;
    m = (m + 64'd536870912) >> 30;
    return p[63] ? -$signed(m) : $signed(m);
  endfunction

  // Scale a by a Q2.30 factor b (|b| <= 1.0), clamping to 64 bits
  function automatic logic signed [63:0] scale_q30(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic neg;
    logic [63:0] ua, ub, hi, lo, t;
    neg = a[63] != b[63];
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    hi = ua >> 32;
    lo = {32'd0, ua[31:0]};
    t = hi * ub * 64'd4 + ((lo * ub + 64'd536870912) >> 30);
    if (!neg) return t[63] ? {1'b0, {63{1'b1}}} : $signed(t);
    if (t >= {1'b1, 63'd0}) return {1'b1, 63'd0};
    return -$signed(t);
  endfunction

  // Clamp a vector component to the 32-bit word
  function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] clamp_one(input logic signed [63:0] v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic logic signed [63:0] dot2(input logic signed [63:0] px, py, qx, qy);
    return clamp_add(px * qx, py * qy);
  endfunction

  function automatic ellipse_result_t predict_ellipse(input logic [15:0] phase);
    logic [31:0] turn;
    logic [1:0] quad;
    logic signed [63:0] z, x, y, nx, c, s;
    logic signed [63:0] rx, ry, vx, vy, d1x, d1y, d2x, d2y, c2, s2, res, nsq;
    ellipse_result_t r;
    // Shift by an eighth of a turn so the top bits pick the quadrant
    turn = {phase, 16'd0} + 32'h2000_0000;
    quad = turn[31:30];
    z = $signed({34'd0, turn[29:0]}) - 64'sd536870912;
    x = ellp_pkg::CORDIC_GAIN_Q30;
    y = 64'sd0;
    for (int i = 0; i < ellp_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ellp_pkg::ATAN_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ellp_pkg::ATAN_TURNS[i];
      end
      x = nx;
    end
    x = clamp_one(x);
    y = clamp_one(y);
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase

    // gamma joins after the single rounding of the axis sum
    rx = round_q30(ax * c + bx * s);
    ry = round_q30(ay * c + by * s);
    vx = clamp_word(rx + gx);
    vy = clamp_word(ry + gy);
    d1x = clamp_word(round_q30(bx * c - ax * s));
    d1y = clamp_word(round_q30(by * c - ay * s));
    d2x = clamp_word(-rx);
    d2y = clamp_word(-ry);

    r.point_x = vx[31:0];
    r.point_y = vy[31:0];
    r.slope_x = d1x[31:0];
    r.slope_y = d1y[31:0];
    r.bend_x = d2x[31:0];
    r.bend_y = d2y[31:0];
    nsq = dot2(vx, vy, vx, vy);
    r.norm_sq = nsq[62:0];
    r.norm_sq_d1 = clamp_add(dot2(vx, vy, d1x, d1y), dot2(vx, vy, d1x, d1y));
    r.norm_sq_d2 = clamp_add(clamp_add(dot2(d1x, d1y, d1x, d1y), dot2(d1x, d1y, d1x, d1y)),
                             clamp_add(dot2(vx, vy, d2x, d2y), dot2(vx, vy, d2x, d2y)));

    // Residual: no alpha.beta cross term
    c2 = round_q30(c * c);
    s2 = round_q30(s * s);
    res = scale_q30(dot2(ax, ay, ax, ay), c2);
    res = clamp_add(res, scale_q30(dot2(bx, by, bx, by), s2));
    res = clamp_add(res, scale_q30(clamp_add(dot2(ax, ay, gx, gy), dot2(ax, ay, gx, gy)), c));
    res = clamp_add(res, scale_q30(clamp_add(dot2(bx, by, gx, gy), dot2(bx, by, gx, gy)), s));
    res = clamp_add(res, dot2(gx, gy, gx, gy));
    r.residual = clamp_add(res, -64'sd4294967296);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Cycle counter and timeout
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ellipse_point_derivative_eval test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: present a phase, hold it while stalled, advance on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (job_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_phase <= job_q[0].phase;
        cur_job <= job_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Record what each accepted transaction must produce
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      if (cur_job.typed_in) pending_q.push_back(cur_job.want);
      else pending_q.push_back(predict_ellipse(cur_job.phase));
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and comparison against the oldest entry
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected result transaction: %p", got);
        mismatches <= mismatches + 1;
      end else begin
        if (got !== pending_q[0]) begin
          if (mismatches < 10) begin
            $display("mismatch point   exp %h %h got %h %h", pending_q[0].point_x,
                     pending_q[0].point_y, got.point_x, got.point_y);
            $display("         slope   exp %h %h got %h %h", pending_q[0].slope_x,
                     pending_q[0].slope_y, got.slope_x, got.slope_y);
            $display("         bend    exp %h %h got %h %h", pending_q[0].bend_x,
                     pending_q[0].bend_y, got.bend_x, got.bend_y);
            $display("         norm_sq exp %h got %h", pending_q[0].norm_sq, got.norm_sq);
            $display("         d1      exp %h got %h", pending_q[0].norm_sq_d1,
                     got.norm_sq_d1);
            $display("         d2      exp %h got %h", pending_q[0].norm_sq_d2,
                     got.norm_sq_d2);
            $display("         resid   exp %h got %h", pending_q[0].residual, got.residual);
          end
          mismatches <= mismatches + 1;
        end
        void'(pending_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // Write one register and mirror it; unknown indexes leave the copy untouched
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      ellp_pkg::REG_ALPHA_X: ax = $signed(val);
      ellp_pkg::REG_ALPHA_Y: ay = $signed(val);
      ellp_pkg::REG_BETA_X:  bx = $signed(val);
      ellp_pkg::REG_BETA_Y:  by = $signed(val);
      ellp_pkg::REG_GAMMA_X: gx = $signed(val);
      ellp_pkg::REG_GAMMA_Y: gy = $signed(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] v [6]);
    write_reg(ellp_pkg::REG_ALPHA_X, v[0]);
    write_reg(ellp_pkg::REG_ALPHA_Y, v[1]);
    write_reg(ellp_pkg::REG_BETA_X,  v[2]);
    write_reg(ellp_pkg::REG_BETA_Y,  v[3]);
    write_reg(ellp_pkg::REG_GAMMA_X, v[4]);
    write_reg(ellp_pkg::REG_GAMMA_Y, v[5]);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  // Hold until every queued phase is sent and every result has come back
  task automatic drain;
    while (job_q.size() > 0 || in_valid || pending_q.size() > 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_reg_value;
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return $urandom_range(32'h0004_0000) - 32'h0002_0000;   // around +-2.0
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_phase;
    logic [15:0] p;
    // Bias towards octant and quadrant boundaries now and then
    if ($urandom_range(4) == 0) begin
      p = {3'($urandom_range(7)), 13'd0};
      return p + 16'($urandom_range(2)) - 16'd1;
    end
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tab [$];
    logic [31:0] cfg_sets [4][6];
    logic [31:0] vals [6];
    ellipse_result_t idle_res;
    phase_job_t job;
    int cur_set;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_phase = '0;
    out_stall = 1'b0;
    cur_job = '0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 7;
    recv_stall_pct = 51;
    ax = '0; ay = '0; bx = '0;
    by = '0; gx = '0; gy = '0;

    // Register sets for the directed part: reset, all high, all low, mixed
    cfg_sets[0] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    cfg_sets[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    cfg_sets[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    cfg_sets[3] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000};

    // With all registers zero only the constant -1.0 survives in the residual
    idle_res = '0;
    idle_res.residual = 64'shFFFF_FFFF_0000_0000;
    dir_tab.push_back('{0, '{1'b1, 16'h0000, idle_res}});
    dir_tab.push_back('{0, '{1'b1, 16'hFFFF, idle_res}});
    dir_tab.push_back('{0, '{1'b1, 16'h4000, idle_res}});
    dir_tab.push_back('{0, '{1'b1, 16'h8000, idle_res}});
    dir_tab.push_back('{0, '{1'b1, 16'hC000, idle_res}});
    dir_tab.push_back('{0, '{1'b1, 16'h1FFF, idle_res}});
    for (int s = 1; s < 4; s++) begin
      dir_tab.push_back('{s, '{1'b0, 16'h0000, '0}});
      dir_tab.push_back('{s, '{1'b0, 16'h2000, '0}});
      dir_tab.push_back('{s, '{1'b0, 16'h4000, '0}});
      dir_tab.push_back('{s, '{1'b0, 16'h8000, '0}});
      dir_tab.push_back('{s, '{1'b0, 16'hC000, '0}});
      dir_tab.push_back('{s, '{1'b0, 16'hFFFF, '0}});
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed walk: rewrite the registers whenever the set changes
    cur_set = 0;
    foreach (dir_tab[r]) begin
      if (dir_tab[r].cfg_set != cur_set) begin
        drain();
        cur_set = dir_tab[r].cfg_set;
        write_all(cfg_sets[cur_set]);
        // Writes to indexes past the last register must be ignored
        write_reg(3'd6, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'hFFFF_FFFF);
      end
      job_q.push_back(dir_tab[r].job);
    end
    drain();

    // Random part: three idling regimes, several register settings in each
    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct  = (regime == 0) ? 7 : (regime == 1) ? 51 : 0;
      recv_stall_pct = (regime == 0) ? 51 : (regime == 1) ? 7 : 0;
      for (int batch = 0; batch < 5; batch++) begin
        foreach (vals[k]) vals[k] = pick_reg_value();
        write_all(vals);
        for (int n = 0; n < 80; n++) begin
          job = '0;
          job.phase = pick_phase();
          job_q.push_back(job);
        end
        drain();
      end
    end

    if (mismatches == 0) begin
      $display("ellipse_point_derivative_eval test passed");
    end else begin
      $display("ellipse_point_derivative_eval test failed");
    end
    $finish;
  end

endmodule

@@ ellipse_point_derivative_eval.f @@
rtl/core/ellp_pkg.sv
rtl/core/ellp_cordic_cell.sv
rtl/core/ellipse_point_derivative_eval.sv
bench/tb.sv
